>>> hdl/vfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types, register indexes and helpers for the voxel face culler.
// ----------------------------------------------------------------------------
package vfc_pkg;

    localparam int TYPE_COUNT = 64;
    localparam int SIDES      = 6;

    localparam int POS_W  = 4;
    localparam int TYPE_W = 6;
    localparam int DIR_W  = 3;
    localparam int IDX_W  = 3;
    localparam int DATA_W = TYPE_COUNT;
    localparam int SIDE_W = 3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_HL_ENABLE = 3'd0;
    localparam logic [IDX_W-1:0] REG_HL_X      = 3'd1;
    localparam logic [IDX_W-1:0] REG_HL_Y      = 3'd2;
    localparam logic [IDX_W-1:0] REG_HL_Z      = 3'd3;
    localparam logic [IDX_W-1:0] REG_NONOPAQUE = 3'd4;
    localparam logic [IDX_W-1:0] REG_PARTIAL   = 3'd5;
    localparam logic [IDX_W-1:0] REG_AIR       = 3'd6;
    localparam logic [IDX_W-1:0] REG_WATER     = 3'd7;

    // Face direction codes
    localparam logic [DIR_W-1:0] DIR_TOP    = 3'd0;
    localparam logic [DIR_W-1:0] DIR_BOTTOM = 3'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT   = 3'd3;
    localparam logic [DIR_W-1:0] DIR_FRONT  = 3'd4;
    localparam logic [DIR_W-1:0] DIR_BACK   = 3'd5;

    typedef struct packed {
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_z;
        logic [TYPE_W-1:0] block_type;
        logic [TYPE_W-1:0] nb_xplus;
        logic [TYPE_W-1:0] nb_xminus;
        logic [TYPE_W-1:0] nb_yplus;
        logic [TYPE_W-1:0] nb_yminus;
        logic [TYPE_W-1:0] nb_zplus;
        logic [TYPE_W-1:0] nb_zminus;
        logic [SIDES-1:0]  neighbor_absent;
    } voxel_req_t;

    typedef struct packed {
        logic [POS_W-1:0]  face_x;
        logic [POS_W-1:0]  face_y;
        logic [POS_W-1:0]  face_z;
        logic [DIR_W-1:0]  face_dir;
        logic [TYPE_W-1:0] face_type;
        logic              highlighted;
        logic              to_transparent;
        logic              last_face;
    } face_t;

    // Per-lane view of the configuration
    typedef struct packed {
        logic [TYPE_W-1:0]     air_code;
        logic [TYPE_W-1:0]     water_code;
        logic                  is_water;
        logic [TYPE_COUNT-1:0] nonopaque_mask;
    } lane_cfg_t;

    // One culled voxel handed to the face emitter
    typedef struct packed {
        logic [SIDES-1:0]  show;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_z;
        logic [TYPE_W-1:0] block_type;
        logic              highlighted;
        logic              to_transparent;
    } voxel_faces_t;

    // Side order +x,-x,+y,-y,+z,-z to face direction code
    function automatic logic [DIR_W-1:0] side_dir(input logic [SIDE_W-1:0] side);
        logic [DIR_W-1:0] dir;
        begin
            case (side)
                3'd0:    dir = DIR_RIGHT;
                3'd1:    dir = DIR_LEFT;
                3'd2:    dir = DIR_TOP;
                3'd3:    dir = DIR_BOTTOM;
                3'd4:    dir = DIR_FRONT;
                default: dir = DIR_BACK;
            endcase
            return dir;
        end
    endfunction

endpackage

>>> hdl/vfc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_lane
// Visibility test for one face: shown when the neighbour is missing, air or
// not opaque, except water against water.
// ----------------------------------------------------------------------------
module vfc_lane (
    input  logic [vfc_pkg::TYPE_W-1:0] nb_type,
    input  logic                       absent,
    input  vfc_pkg::lane_cfg_t         cfg,
    output logic                       show
);
    import vfc_pkg::*;

    logic water_pair;
    logic see_through;

    // neighbour classification
    assign water_pair  = cfg.is_water && (nb_type == cfg.water_code);
    assign see_through = (nb_type == cfg.air_code) || cfg.nonopaque_mask[nb_type];

    assign show = absent || (!water_pair && see_through);

endmodule

>>> hdl/vfc_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_merge
// Collects the lane results of one voxel and emits its visible faces one per
// cycle, lowest side first, through a registered output.
// ----------------------------------------------------------------------------
module vfc_merge (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  vfc_pkg::voxel_faces_t item,
    output logic                  busy,
    output logic                  valid,
    output vfc_pkg::face_t        face
);
    import vfc_pkg::*;

    logic [SIDES-1:0]  mask_reg;
    logic [SIDES-1:0]  mask_next;
    logic [SIDES-1:0]  mask_rest;
    logic [SIDES-1:0]  low_bit;
    logic [SIDE_W-1:0] low_idx;
    voxel_faces_t      item_reg;
    logic              valid_reg;
    face_t             face_reg;
    face_t             face_next;

    // lowest pending side and what is left after it
    assign mask_rest = mask_reg & (mask_reg - SIDES'(1));
    assign low_bit   = mask_reg & ~mask_rest;

    always_comb
    begin
        low_idx = '0;
        for (int i = 0; i < SIDES; i++)
        begin
            if (low_bit[i])
            begin
                low_idx = SIDE_W'(i);
            end
        end
    end

    // more than one face left: this cycle does not finish the voxel
    assign busy      = (mask_rest != '0);
    assign mask_next = load ? item.show : mask_rest;

    // face selected this cycle, registered onto the output
    always_comb
    begin
        face_next.face_x         = item_reg.pos_x;
        face_next.face_y         = item_reg.pos_y;
        face_next.face_z         = item_reg.pos_z;
        face_next.face_dir       = side_dir(low_idx);
        face_next.face_type      = item_reg.block_type;
        face_next.highlighted    = item_reg.highlighted;
        face_next.to_transparent = item_reg.to_transparent;
        face_next.last_face      = (mask_rest == '0);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg  <= mask_next;
            valid_reg <= (mask_reg != '0);
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
        face_reg <= face_next;
    end

    assign valid = valid_reg;
    assign face  = face_reg;

    // pending faces always produce an output strobe next cycle
    a_pending_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (mask_reg != '0) |=> valid_reg)
        else $error("pending face not emitted");

    // without a new voxel each cycle removes exactly one pending face
    a_one_per_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (!load && mask_reg != '0) |=>
            ($countones(mask_reg) == $countones($past(mask_reg)) - 1))
        else $error("face count did not drop by one");

    // a voxel is only taken when the current one is on its final face
    a_load_last: assert property (@(posedge clk) disable iff (!rst_n)
        (load && mask_reg != '0) |=> (valid_reg && face_reg.last_face))
        else $error("voxel replaced before its last face");

endmodule

>>> hdl/voxel_face_culler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_culler
// Hidden-face culling for one voxel per request: six lanes test the faces in
// parallel, the merge stage emits visible faces one per cycle.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its faces appear on
// face with valid, one per cycle, after the emitter's mask and item registers
// and its face output register, in side order +x,-x,+y,-y,+z,-z; last_face
// marks the final one. A voxel has up to six visible faces and holds busy high
// while more than one of them is still pending; a voxel with zero or one face
// (air voxels give none) lets the next request in on the following cycle. The
// rate is set by the single face output port. valid is a one-cycle strobe: the
// receiver must take every face as it comes. Configuration writes take
// effect at once and belong between requests.
// ----------------------------------------------------------------------------
module voxel_face_culler (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  vfc_pkg::voxel_req_t        req,
    output logic                       valid,
    output vfc_pkg::face_t             face,
    input  logic                       cfg_we,
    input  logic [vfc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [vfc_pkg::DATA_W-1:0] cfg_data
);
    import vfc_pkg::*;

    logic                  hl_enable_reg;
    logic [POS_W-1:0]      hl_x_reg;
    logic [POS_W-1:0]      hl_y_reg;
    logic [POS_W-1:0]      hl_z_reg;
    logic [TYPE_COUNT-1:0] nonopaque_reg;
    logic [TYPE_COUNT-1:0] partial_reg;
    logic [TYPE_W-1:0]     air_reg;
    logic [TYPE_W-1:0]     water_reg;

    logic              accept;
    logic              is_air;
    lane_cfg_t         lane_cfg;
    logic [TYPE_W-1:0] nb_type [SIDES];
    logic [SIDES-1:0]  lane_show;
    voxel_faces_t      item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hl_enable_reg <= 1'b0;
            hl_x_reg      <= '0;
            hl_y_reg      <= '0;
            hl_z_reg      <= '0;
            nonopaque_reg <= '0;
            partial_reg   <= '0;
            air_reg       <= '0;
            water_reg     <= TYPE_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HL_ENABLE: hl_enable_reg <= cfg_data[0];
                REG_HL_X:      hl_x_reg      <= cfg_data[POS_W-1:0];
                REG_HL_Y:      hl_y_reg      <= cfg_data[POS_W-1:0];
                REG_HL_Z:      hl_z_reg      <= cfg_data[POS_W-1:0];
                REG_NONOPAQUE: nonopaque_reg <= cfg_data[TYPE_COUNT-1:0];
                REG_PARTIAL:   partial_reg   <= cfg_data[TYPE_COUNT-1:0];
                REG_AIR:       air_reg       <= cfg_data[TYPE_W-1:0];
                REG_WATER:     water_reg     <= cfg_data[TYPE_W-1:0];
                default:       ;
            endcase
        end
    end

    assign accept = start && !busy;
    assign is_air = (req.block_type == air_reg);

    // shared lane configuration
    assign lane_cfg.air_code       = air_reg;
    assign lane_cfg.water_code     = water_reg;
    assign lane_cfg.is_water       = (req.block_type == water_reg);
    assign lane_cfg.nonopaque_mask = nonopaque_reg;

    // neighbours in side order +x,-x,+y,-y,+z,-z
    assign nb_type[0] = req.nb_xplus;
    assign nb_type[1] = req.nb_xminus;
    assign nb_type[2] = req.nb_yplus;
    assign nb_type[3] = req.nb_yminus;
    assign nb_type[4] = req.nb_zplus;
    assign nb_type[5] = req.nb_zminus;

    // one visibility lane per face
    for (genvar s = 0; s < SIDES; s++)
    begin : g_lane
        vfc_lane u_lane (
            .nb_type (nb_type[s]),
            .absent  (req.neighbor_absent[s]),
            .cfg     (lane_cfg),
            .show    (lane_show[s])
        );
    end

    // voxel summary for the emitter
    assign item.show           = is_air ? '0 : lane_show;
    assign item.pos_x          = req.pos_x;
    assign item.pos_y          = req.pos_y;
    assign item.pos_z          = req.pos_z;
    assign item.block_type     = req.block_type;
    assign item.highlighted    = hl_enable_reg && (req.pos_x == hl_x_reg) &&
                                 (req.pos_y == hl_y_reg) && (req.pos_z == hl_z_reg);
    assign item.to_transparent = partial_reg[req.block_type];

    vfc_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .item  (item),
        .busy  (busy),
        .valid (valid),
        .face  (face)
    );

endmodule

>>> tb/sv/tb_voxel_face_culler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_face_culler
// Self-checking testbench for the voxel face culler. Directed voxels cover
// the culling rules, the type masks, highlighting and air/water overlap.
// Random voxels follow under several register settings and request-side
// idle mixes. A local predictor queues the faces each voxel should emit,
// and a checker compares every face strobe against that queue.
// ----------------------------------------------------------------------------
module tb_voxel_face_culler;

    import vfc_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int DRAIN_CYCLES = 8;     // long enough for the first face and up to six faces
    localparam int QUIET_LIMIT  = 2000;

    // Block type codes used by the directed tests
    localparam logic [TYPE_W-1:0] T_AIR   = 6'd0;
    localparam logic [TYPE_W-1:0] T_WATER = 6'd1;
    localparam logic [TYPE_W-1:0] T_STONE = 6'd5;
    localparam logic [TYPE_W-1:0] T_GLASS = 6'd7;
    localparam logic [TYPE_W-1:0] T_LEAF  = 6'd9;
    localparam logic [TYPE_W-1:0] T_TOP   = 6'd63;

    typedef struct packed {
        logic                  hl_enable;
        logic [POS_W-1:0]      hl_x;
        logic [POS_W-1:0]      hl_y;
        logic [POS_W-1:0]      hl_z;
        logic [TYPE_COUNT-1:0] nonopaque_mask;
        logic [TYPE_COUNT-1:0] partial_mask;
        logic [TYPE_W-1:0]     air_code;
        logic [TYPE_W-1:0]     water_code;
    } cull_cfg_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    logic                busy;
    voxel_req_t          req       = '0;
    logic                valid;
    face_t               face;
    logic                cfg_we    = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [DATA_W-1:0]   cfg_data  = '0;

    cull_cfg_t  active_cfg;
    face_t      visible_faces [$];
    int         idle_pct       = 0;
    int         mismatch_count = 0;
    int         voxels_sent    = 0;
    int         faces_checked  = 0;
    int         cfg_settings   = 0;
    int         quiet_cycles   = 0;

    voxel_face_culler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .valid     (valid),
        .face      (face),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor: faces a voxel should produce under the current registers
    // ------------------------------------------------------------------------
    function automatic void predict_visible_faces(input voxel_req_t v);
        logic [TYPE_W-1:0] nb [SIDES];
        logic [DIR_W-1:0]  dir_of_side [SIDES];
        logic [SIDES-1:0]  show_mask;
        logic              is_water;
        face_t             f;
        nb = '{v.nb_xplus, v.nb_xminus, v.nb_yplus, v.nb_yminus, v.nb_zplus, v.nb_zminus};
        dir_of_side = '{DIR_RIGHT, DIR_LEFT, DIR_TOP, DIR_BOTTOM, DIR_FRONT, DIR_BACK};
        // air wins over everything, even when it shares the water code
        if (v.block_type == active_cfg.air_code)
            return;
        is_water = (v.block_type == active_cfg.water_code);
        for (int s = 0; s < SIDES; s++)
        begin
            if (v.neighbor_absent[s])
                show_mask[s] = 1'b1;
            else if (is_water && nb[s] == active_cfg.water_code)
                show_mask[s] = 1'b0;
            else
                show_mask[s] = (nb[s] == active_cfg.air_code) ||
                               active_cfg.nonopaque_mask[nb[s]];
        end
        f.face_x         = v.pos_x;
        f.face_y         = v.pos_y;
        f.face_z         = v.pos_z;
        f.face_type      = v.block_type;
        f.highlighted    = active_cfg.hl_enable && v.pos_x == active_cfg.hl_x &&
                           v.pos_y == active_cfg.hl_y && v.pos_z == active_cfg.hl_z;
        f.to_transparent = active_cfg.partial_mask[v.block_type];
        for (int s = 0; s < SIDES; s++)
        begin
            if (show_mask[s])
            begin
                f.face_dir  = dir_of_side[s];
                f.last_face = ((show_mask >> (s + 1)) == '0);
                visible_faces.push_back(f);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Face checker: every strobe is matched against the oldest expected face
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : face_checker
        face_t want;
        if (rst_n && valid)
        begin
            if (visible_faces.size() == 0)
            begin
                $error("unexpected face: dir %0d at (%0d,%0d,%0d) type %0d",
                       face.face_dir, face.face_x, face.face_y, face.face_z,
                       face.face_type);
                mismatch_count++;
            end
            else
            begin
                want = visible_faces.pop_front();
                faces_checked++;
                check_field("face_x", want.face_x, face.face_x);
                check_field("face_y", want.face_y, face.face_y);
                check_field("face_z", want.face_z, face.face_z);
                check_field("face_dir", want.face_dir, face.face_dir);
                check_field("face_type", want.face_type, face.face_type);
                check_field("highlighted", want.highlighted, face.highlighted);
                check_field("to_transparent", want.to_transparent, face.to_transparent);
                check_field("last_face", want.last_face, face.last_face);
            end
        end
    end

    // Watchdog: cycles with neither a request taken nor a face strobed
    always @(posedge clk)
    begin
        if ((start && !busy) || valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // start stays high after a request is taken; the next call either keeps
    // it high or drops it, so it is assigned once in that time step.
    task automatic issue_voxel(input voxel_req_t v);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        start <= 1'b1;
        req   <= v;
        do
            @(posedge clk);
        while (busy);
        voxels_sent++;
        predict_visible_faces(v);
    endtask

    // Stop requesting until every expected face has come out, then let the
    // pipeline settle in case the last voxel produced nothing.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (visible_faces.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [IDX_W-1:0] index, input logic [DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Optionally fill the bits above a narrow register with noise
    function automatic logic [DATA_W-1:0] pad_reg(input logic [DATA_W-1:0] val,
                                                  input int width, input bit noisy);
        logic [DATA_W-1:0] noise;
        noise = {$urandom, $urandom};
        return noisy ? (val | (noise << width)) : val;
    endfunction

    // Must be called only while the block is idle
    task automatic apply_config(input cull_cfg_t c, input bit noisy);
        active_cfg = c;
        cfg_settings++;
        put_reg(REG_HL_ENABLE, pad_reg(DATA_W'(c.hl_enable), 1, noisy));
        put_reg(REG_HL_X, pad_reg(DATA_W'(c.hl_x), POS_W, noisy));
        put_reg(REG_HL_Y, pad_reg(DATA_W'(c.hl_y), POS_W, noisy));
        put_reg(REG_HL_Z, pad_reg(DATA_W'(c.hl_z), POS_W, noisy));
        put_reg(REG_NONOPAQUE, c.nonopaque_mask);
        put_reg(REG_PARTIAL, c.partial_mask);
        put_reg(REG_AIR, pad_reg(DATA_W'(c.air_code), TYPE_W, noisy));
        put_reg(REG_WATER, pad_reg(DATA_W'(c.water_code), TYPE_W, noisy));
        cfg_we <= 1'b0;
    endtask

    function automatic voxel_req_t voxel_of(input logic [POS_W-1:0] px,
                                            input logic [POS_W-1:0] py,
                                            input logic [POS_W-1:0] pz,
                                            input logic [TYPE_W-1:0] bt,
                                            input logic [TYPE_W-1:0] nb,
                                            input logic [SIDES-1:0] absent);
        voxel_req_t v;
        v.pos_x           = px;
        v.pos_y           = py;
        v.pos_z           = pz;
        v.block_type      = bt;
        v.nb_xplus        = nb;
        v.nb_xminus       = nb;
        v.nb_yplus        = nb;
        v.nb_yminus       = nb;
        v.nb_zplus        = nb;
        v.nb_zminus       = nb;
        v.neighbor_absent = absent;
        return v;
    endfunction

    // Neighbor code biased toward the codes that change the outcome
    function automatic logic [TYPE_W-1:0] pick_neighbor(input logic [TYPE_W-1:0] bt);
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return active_cfg.air_code;
        else if (r < 45)
            return active_cfg.water_code;
        else if (r < 55)
            return bt;
        return TYPE_W'($urandom_range(63));
    endfunction

    function automatic voxel_req_t random_voxel();
        voxel_req_t v;
        int         r;
        if ($urandom_range(99) < 15)
        begin
            v.pos_x = active_cfg.hl_x;
            v.pos_y = active_cfg.hl_y;
            v.pos_z = active_cfg.hl_z;
        end
        else
        begin
            v.pos_x = POS_W'($urandom_range(15));
            v.pos_y = POS_W'($urandom_range(15));
            v.pos_z = POS_W'($urandom_range(15));
        end
        r = $urandom_range(99);
        if (r < 10)
            v.block_type = active_cfg.air_code;
        else if (r < 30)
            v.block_type = active_cfg.water_code;
        else
            v.block_type = TYPE_W'($urandom_range(63));
        v.nb_xplus  = pick_neighbor(v.block_type);
        v.nb_xminus = pick_neighbor(v.block_type);
        v.nb_yplus  = pick_neighbor(v.block_type);
        v.nb_yminus = pick_neighbor(v.block_type);
        v.nb_zplus  = pick_neighbor(v.block_type);
        v.nb_zminus = pick_neighbor(v.block_type);
        r = $urandom_range(99);
        if (r < 60)
            v.neighbor_absent = '0;
        else if (r < 75)
            v.neighbor_absent = SIDES'($urandom_range(63));
        else if (r < 85)
            v.neighbor_absent = '1;
        else
            v.neighbor_absent = SIDES'(1) << $urandom_range(SIDES - 1);
        return v;
    endfunction

    function automatic cull_cfg_t random_cull_cfg();
        cull_cfg_t c;
        c.hl_enable      = 1'b1;
        c.hl_x           = POS_W'($urandom_range(15));
        c.hl_y           = POS_W'($urandom_range(15));
        c.hl_z           = POS_W'($urandom_range(15));
        c.nonopaque_mask = {$urandom, $urandom};
        c.partial_mask   = {$urandom, $urandom};
        c.air_code       = TYPE_W'($urandom_range(63));
        c.water_code     = TYPE_W'($urandom_range(63));
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Registers at reset: air 0, water 1, every type opaque and solid
    task automatic test_culling_rules();
        voxel_req_t v;
        issue_voxel(voxel_of(4'd3, 4'd7, 4'd1, T_AIR, T_AIR, '1));          // air voxel
        issue_voxel(voxel_of(4'd0, 4'd0, 4'd0, T_STONE, T_AIR, '0));        // all faces
        issue_voxel(voxel_of(4'd15, 4'd15, 4'd15, T_TOP, T_STONE, '0));     // buried
        issue_voxel(voxel_of(4'd15, 4'd0, 4'd15, T_STONE, T_STONE, '1));    // chunk edge
        v = voxel_of(4'd8, 4'd4, 4'd2, T_STONE, T_STONE, '0);
        v.nb_xplus  = T_AIR;
        v.nb_yminus = T_AIR;
        v.nb_zminus = T_AIR;
        issue_voxel(v);
        issue_voxel(voxel_of(4'd5, 4'd10, 4'd12, T_STONE, T_STONE, 6'b010110));
        issue_voxel(voxel_of(4'd1, 4'd2, 4'd3, T_WATER, T_WATER, '0));
        issue_voxel(voxel_of(4'd1, 4'd2, 4'd4, T_WATER, T_WATER, 6'b100001));
    endtask

    task automatic test_type_masks();
        cull_cfg_t  c;
        voxel_req_t v;
        wait_drained();
        c = active_cfg;
        c.nonopaque_mask = '0;
        c.nonopaque_mask[T_WATER] = 1'b1;
        c.nonopaque_mask[T_GLASS] = 1'b1;
        c.nonopaque_mask[T_TOP]   = 1'b1;
        c.partial_mask = '0;
        c.partial_mask[T_AIR]   = 1'b1;
        c.partial_mask[T_WATER] = 1'b1;
        c.partial_mask[T_TOP]   = 1'b1;
        apply_config(c, 1'b0);
        issue_voxel(voxel_of(4'd2, 4'd2, 4'd2, T_STONE, T_GLASS, '0));
        // water against water stays hidden although water is not opaque
        issue_voxel(voxel_of(4'd3, 4'd3, 4'd3, T_WATER, T_WATER, '0));
        v = voxel_of(4'd4, 4'd9, 4'd14, T_WATER, T_WATER, '0);
        v.nb_xplus  = T_GLASS;
        v.nb_yminus = T_AIR;
        v.nb_zplus  = T_TOP;
        v.nb_zminus = T_STONE;
        issue_voxel(v);
        issue_voxel(voxel_of(4'd6, 4'd1, 4'd11, T_TOP, T_WATER, '0));
        issue_voxel(voxel_of(4'd7, 4'd7, 4'd7, T_GLASS, T_GLASS, '0));
        // every type see-through and partial
        wait_drained();
        c.nonopaque_mask = '1;
        c.partial_mask   = '1;
        apply_config(c, 1'b0);
        issue_voxel(voxel_of(4'd9, 4'd13, 4'd0, T_STONE, T_STONE, '0));
    endtask

    task automatic test_highlight();
        cull_cfg_t c;
        wait_drained();
        c = active_cfg;
        c.nonopaque_mask = '0;
        c.partial_mask   = '0;
        c.hl_enable      = 1'b1;
        c.hl_x           = 4'd15;
        c.hl_y           = 4'd0;
        c.hl_z           = 4'd9;
        apply_config(c, 1'b1);
        issue_voxel(voxel_of(4'd15, 4'd0, 4'd9, T_STONE, T_AIR, 6'b000011));
        issue_voxel(voxel_of(4'd14, 4'd0, 4'd9, T_STONE, T_AIR, 6'b000011));
        issue_voxel(voxel_of(4'd15, 4'd1, 4'd9, T_STONE, T_AIR, 6'b000011));
        issue_voxel(voxel_of(4'd15, 4'd0, 4'd8, T_STONE, T_AIR, 6'b000011));
        wait_drained();
        c.hl_enable = 1'b0;
        apply_config(c, 1'b1);
        issue_voxel(voxel_of(4'd15, 4'd0, 4'd9, T_STONE, T_AIR, 6'b000011));
    endtask

    // Air and water share one code: the voxel counts as air
    task automatic test_air_is_water();
        cull_cfg_t c;
        wait_drained();
        c = active_cfg;
        c.air_code   = T_LEAF;
        c.water_code = T_LEAF;
        apply_config(c, 1'b0);
        issue_voxel(voxel_of(4'd11, 4'd12, 4'd13, T_LEAF, T_LEAF, '1));
        issue_voxel(voxel_of(4'd11, 4'd12, 4'd14, T_STONE, T_LEAF, '0));
    endtask

    task automatic run_random_phase(input cull_cfg_t c, input int pct, input int count);
        wait_drained();
        apply_config(c, 1'b1);
        idle_pct = pct;
        repeat (count)
        begin
            // now and then hold off until the block has emptied
            if ($urandom_range(19) == 0)
                wait_drained();
            issue_voxel(random_voxel());
        end
    endtask

    task automatic test_random_traffic();
        cull_cfg_t c;
        run_random_phase(random_cull_cfg(), 0, 25);
        c = random_cull_cfg();
        c.nonopaque_mask = '0;
        c.partial_mask   = '0;
        c.air_code       = 6'd63;
        c.water_code     = 6'd0;
        run_random_phase(c, 76, 25);
        c = random_cull_cfg();
        c.nonopaque_mask = '1;
        c.partial_mask   = '1;
        run_random_phase(c, 31, 25);
        run_random_phase(random_cull_cfg(), 0, 25);
        idle_pct = 0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        active_cfg            = '0;
        active_cfg.water_code = T_WATER;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_culling_rules();
        test_type_masks();
        test_highlight();
        test_air_is_water();
        test_random_traffic();
        wait_drained();

        $display("Checked %0d faces from %0d voxels across %0d register settings,",
                 faces_checked, voxels_sent, cfg_settings);
        $display("with request idle mixes of 0, 31 and 76 percent.");
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
